// ===== hdl/nprc_pkg.sv =====
// Shared types, constants and the control store for the normal-pattern reachability block.
// Used by nprc_sequencer, nprc_datapath and normal_pattern_reachability; depends on nothing.
package nprc_pkg;

  // Field widths of the request, the result and the register port.
  localparam int SW_W      = 7;   // strip_width register
  localparam int TT_W      = 5;   // type_total register
  localparam int SLOT_W    = 4;
  localparam int IW_W      = 7;   // item width
  localparam int DEM_W     = 8;   // item demand
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 7;

  localparam int DEF_MAX_TYPES = 16;
  localparam int DEF_MAX_WIDTH = 64;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_TOTAL  = 1'b1;

  // Request kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Program steps.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_RDOWN  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_CHKOWN = 4'd2;
  localparam logic [STEP_W-1:0] STEP_RDT    = 4'd3;
  localparam logic [STEP_W-1:0] STEP_LDT    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SHF    = 4'd5;
  localparam logic [STEP_W-1:0] STEP_NXT    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_FIN    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_CNT    = 4'd8;
  localparam logic [STEP_W-1:0] STEP_OUT    = 4'd9;

  // Jump conditions.
  localparam int COND_W = 4;
  localparam logic [COND_W-1:0] COND_NEVER     = 4'd0;
  localparam logic [COND_W-1:0] COND_ALWAYS    = 4'd1;
  localparam logic [COND_W-1:0] COND_QUERY     = 4'd2;
  localparam logic [COND_W-1:0] COND_EMPTY     = 4'd3;
  localparam logic [COND_W-1:0] COND_T_END     = 4'd4;
  localparam logic [COND_W-1:0] COND_SKIP      = 4'd5;
  localparam logic [COND_W-1:0] COND_SHIFT_END = 4'd6;
  localparam logic [COND_W-1:0] COND_CNT_END   = 4'd7;
  localparam logic [COND_W-1:0] COND_OUT_FREE  = 4'd8;

  // Datapath operations of one step.
  typedef struct packed {
    logic accept;   // request port open
    logic rd_own;   // table read at the queried slot, else at the type counter
    logic chk;      // latch own width, seed the mask, clear the type counter
    logic ld_t;     // latch the current type's width and copy count
    logic shift;    // one shift-OR of the mask
    logic inc_t;    // advance to the next type
    logic fin;      // clip the mask to the strip and to the fitting starts
    logic cnt;      // count one byte of the final mask
    logic out_ld;   // move the result into the output register
  } nprc_op_t;

  typedef struct packed {
    logic [COND_W-1:0] cond;
    logic              hold;    // stay on this step when the condition is false
    logic [STEP_W-1:0] target;
    nprc_op_t          op;
  } nprc_uword_t;

  // Status flags the sequencer branches on.
  typedef struct packed {
    logic query_acc;
    logic empty;
    logic t_end;
    logic skip;
    logic shift_end;
    logic cnt_end;
    logic out_free;
  } nprc_stat_t;

  function automatic nprc_uword_t ucode_rom(input logic [STEP_W-1:0] pc);
    nprc_uword_t w;
    w = '0;
    case (pc)
      STEP_IDLE: begin
        w.cond = COND_QUERY;   w.hold = 1'b1; w.target = STEP_RDOWN;
        w.op.accept = 1'b1;
      end
      STEP_RDOWN: begin
        w.cond = COND_NEVER;   w.target = STEP_IDLE;
        w.op.rd_own = 1'b1;
      end
      STEP_CHKOWN: begin
        w.cond = COND_EMPTY;   w.target = STEP_FIN;
        w.op.chk = 1'b1;
      end
      STEP_RDT: begin
        w.cond = COND_T_END;   w.target = STEP_FIN;
      end
      STEP_LDT: begin
        w.cond = COND_SKIP;    w.target = STEP_NXT;
        w.op.ld_t = 1'b1;
      end
      STEP_SHF: begin
        w.cond = COND_SHIFT_END; w.hold = 1'b1; w.target = STEP_NXT;
        w.op.shift = 1'b1;
      end
      STEP_NXT: begin
        w.cond = COND_ALWAYS;  w.target = STEP_RDT;
        w.op.inc_t = 1'b1;
      end
      STEP_FIN: begin
        w.cond = COND_NEVER;   w.target = STEP_IDLE;
        w.op.fin = 1'b1;
      end
      STEP_CNT: begin
        w.cond = COND_CNT_END; w.hold = 1'b1; w.target = STEP_OUT;
        w.op.cnt = 1'b1;
      end
      STEP_OUT: begin
        w.cond = COND_OUT_FREE; w.hold = 1'b1; w.target = STEP_IDLE;
        w.op.out_ld = 1'b1;
      end
      default: begin
        w.cond = COND_ALWAYS;  w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/normal_pattern_reachability.sv =====
// Top level of the normal-pattern reachability block: register port and the two submodules.
// Depends on nprc_pkg, nprc_sequencer and nprc_datapath.
//
// The block keeps a table of item types (width and demand per slot) and answers queries
// for the normal-pattern start positions of one slot within a strip of strip_width
// positions. A load request (kind 0) writes one slot and leaves the block idle; it
// gives no result. A query request (kind 1) gives exactly one result with the slot, the
// start mask and the number of starts. A query occupies the block while it walks the
// types taking part (type_total, capped at MAX_TYPES), reading each in turn from the
// type table. The single shift-OR unit handles one copy per cycle and runs once per
// counted copy of each type whose width is nonzero and below the strip, stopping early
// on a type once another copy adds no new start, so at most the sum of the counted
// demands in all. A byte-wide counter then forms start_count. A query of an empty case
// (an empty strip, zero demand, a width above the strip, a slot outside type_total)
// skips the walk. Control comes from a ten-step program in a read-only table that the
// sequencer walks. The block takes a new request once the previous query has moved its
// result into the output register, so a waiting result does not stop the next query
// from running. Slots must be loaded before they are queried; an unloaded slot gives an
// undefined mask. The user must write registers through the cfg port only while no
// request is in flight; the block itself does not enforce this. Index 0 is strip_width
// (reset 64, capped at MAX_WIDTH), index 1 is type_total (reset 0).
module normal_pattern_reachability
  import nprc_pkg::*;
#(
  parameter int MAX_TYPES = DEF_MAX_TYPES,
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int CNT_W    = $clog2(MAX_WIDTH + 1)
)(
  input  logic                 clk,
  input  logic                 rst_n,
  // Register write port.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  // Request channel.
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  input  logic [SLOT_W-1:0]    in_slot,
  input  logic [IW_W-1:0]      in_item_width,
  input  logic [DEM_W-1:0]     in_item_demand,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SLOT_W-1:0]    out_queried_slot,
  output logic [MAX_WIDTH-1:0] out_start_mask,
  output logic [CNT_W-1:0]     out_start_count
);

  logic [SW_W-1:0] strip_width_r;
  logic [TT_W-1:0] type_total_r;
  logic [SW_W-1:0] w_eff;
  logic [TT_W-1:0] n_eff;
  nprc_op_t        op;
  nprc_stat_t      stat;

  // Register writes are always taken at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_width_r <= SW_W'(64);
      type_total_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STRIP_WIDTH: strip_width_r <= cfg_data[SW_W-1:0];
        CFG_TYPE_TOTAL:  type_total_r  <= cfg_data[TT_W-1:0];
        default:         ;
      endcase
    end
  end

  // Values above the built sizes saturate to them.
  assign w_eff = (32'(strip_width_r) > MAX_WIDTH) ? SW_W'(MAX_WIDTH) : strip_width_r;
  assign n_eff = (32'(type_total_r) > MAX_TYPES) ? TT_W'(MAX_TYPES) : type_total_r;

  nprc_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  nprc_datapath #(
    .MAX_TYPES (MAX_TYPES),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .stat             (stat),
    .w_eff            (w_eff),
    .n_eff            (n_eff),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_slot          (in_slot),
    .in_item_width    (in_item_width),
    .in_item_demand   (in_item_demand),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_queried_slot (out_queried_slot),
    .out_start_mask   (out_start_mask),
    .out_start_count  (out_start_count)
  );

endmodule

// ===== hdl/nprc_sequencer.sv =====
// Step counter and control store walker for the normal-pattern reachability block.
// Depends on nprc_pkg for the program, the control word and the status flags.
module nprc_sequencer
  import nprc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  nprc_stat_t stat,
  output nprc_op_t   op
);

  logic [STEP_W-1:0] pc_r, pc_nxt;
  nprc_uword_t       uword;
  logic              take;

  assign uword = ucode_rom(pc_r);
  assign op    = uword.op;

  always_comb begin
    case (uword.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_QUERY:     take = stat.query_acc;
      COND_EMPTY:     take = stat.empty;
      COND_T_END:     take = stat.t_end;
      COND_SKIP:      take = stat.skip;
      COND_SHIFT_END: take = stat.shift_end;
      COND_CNT_END:   take = stat.cnt_end;
      COND_OUT_FREE:  take = stat.out_free;
      default:        take = 1'b1;
    endcase
  end

  always_comb begin
    if (take) begin
      pc_nxt = uword.target;
    end else if (uword.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // A query request always starts the table read of its own slot next.
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == STEP_IDLE && stat.query_acc) |=> (pc_r == STEP_RDOWN))
    else $error("query request did not start the slot read");

endmodule

// ===== hdl/nprc_datapath.sv =====
// Type tables, reach mask, shift-OR unit, bit counter and output register.
// Depends on nprc_pkg; driven step by step by nprc_sequencer.
module nprc_datapath
  import nprc_pkg::*;
#(
  parameter int MAX_TYPES = DEF_MAX_TYPES,
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int CNT_W    = $clog2(MAX_WIDTH + 1)
)(
  input  logic                 clk,
  input  logic                 rst_n,
  input  nprc_op_t             op,
  output nprc_stat_t           stat,
  input  logic [SW_W-1:0]      w_eff,
  input  logic [TT_W-1:0]      n_eff,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  input  logic [SLOT_W-1:0]    in_slot,
  input  logic [IW_W-1:0]      in_item_width,
  input  logic [DEM_W-1:0]     in_item_demand,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SLOT_W-1:0]    out_queried_slot,
  output logic [MAX_WIDTH-1:0] out_start_mask,
  output logic [CNT_W-1:0]     out_start_count
);

  localparam int TIDX_W = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
  localparam int NCHUNK = (MAX_WIDTH + 7) / 8;
  localparam int CSH_W  = NCHUNK * 8;
  localparam int CH_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

  logic [IW_W-1:0]  width_mem  [MAX_TYPES];
  logic [DEM_W-1:0] demand_mem [MAX_TYPES];

  logic [IW_W-1:0]      rd_w_r;
  logic [DEM_W-1:0]     rd_d_r;
  logic [TIDX_W-1:0]    rd_addr;
  logic [SLOT_W-1:0]    j_r;
  logic [TT_W-1:0]      t_r;
  logic [DEM_W-1:0]     k_r;
  logic [IW_W-1:0]      tw_r;
  logic [IW_W-1:0]      own_w_r;
  logic [MAX_WIDTH-1:0] mask_r;
  logic [CSH_W-1:0]     cnt_sh_r;
  logic [CH_W-1:0]      chunk_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 out_valid_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic [MAX_WIDTH-1:0] out_mask_r;
  logic [CNT_W-1:0]     out_count_r;

  logic                 in_acc;
  logic                 load_ok;
  logic [MAX_WIDTH-1:0] wmask;
  logic [MAX_WIDTH-1:0] fitmask;
  logic [7:0]           room;
  logic [MAX_WIDTH-1:0] shift_nxt;
  logic [DEM_W-1:0]     lim;
  logic [3:0]           pop8;
  logic                 out_free;

  assign in_ready = op.accept;
  assign in_acc   = in_valid && in_ready;
  assign load_ok  = in_acc && (in_kind == KIND_LOAD) && (32'(in_slot) < MAX_TYPES);

  // One write port and one read port: one write per load, one registered read per cycle.
  assign rd_addr = op.rd_own ? TIDX_W'(j_r) : TIDX_W'(t_r);

  always_ff @(posedge clk) begin
    if (load_ok) begin
      width_mem[TIDX_W'(in_slot)]  <= in_item_width;
      demand_mem[TIDX_W'(in_slot)] <= in_item_demand;
    end
    rd_w_r <= width_mem[rd_addr];
    rd_d_r <= demand_mem[rd_addr];
  end

  // Strip mask and the starts at which the queried item still fits.
  assign room = {1'b0, w_eff} - {1'b0, own_w_r};
  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      wmask[i]   = (7'(i) < w_eff);
      fitmask[i] = (8'(i) <= room);
    end
  end

  assign shift_nxt = mask_r | ((mask_r << tw_r) & wmask);
  assign lim = rd_d_r - DEM_W'((t_r == TT_W'(j_r)) ? 1 : 0);

  always_comb begin
    pop8 = '0;
    for (int i = 0; i < 8; i++) begin
      pop8 = pop8 + 4'(cnt_sh_r[i]);
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    stat.query_acc = in_acc && (in_kind == KIND_QUERY);
    stat.empty     = (w_eff == '0) || (TT_W'(j_r) >= n_eff) || (32'(j_r) >= MAX_TYPES) ||
                     (rd_d_r == '0) || (rd_w_r > w_eff);
    stat.t_end     = (t_r >= n_eff);
    stat.skip      = (rd_w_r == '0) || (rd_w_r >= w_eff) || (lim == '0);
    stat.shift_end = (shift_nxt == mask_r) || (k_r == DEM_W'(1));
    stat.cnt_end   = (chunk_r == CH_W'(NCHUNK - 1));
    stat.out_free  = out_free;
  end

  always_ff @(posedge clk) begin
    if (stat.query_acc) begin
      j_r <= in_slot;
    end
    if (op.chk) begin
      own_w_r <= rd_w_r;
      mask_r  <= stat.empty ? '0 : MAX_WIDTH'(1);
      t_r     <= '0;
    end
    if (op.ld_t) begin
      tw_r <= rd_w_r;
      k_r  <= lim;
    end
    if (op.shift) begin
      mask_r <= shift_nxt;
      k_r    <= k_r - 1'b1;
    end
    if (op.inc_t) begin
      t_r <= t_r + 1'b1;
    end
    if (op.fin) begin
      mask_r   <= mask_r & wmask & fitmask;
      cnt_sh_r <= CSH_W'(mask_r & wmask & fitmask);
      chunk_r  <= '0;
      cnt_r    <= '0;
    end
    if (op.cnt) begin
      cnt_sh_r <= cnt_sh_r >> 8;
      chunk_r  <= chunk_r + 1'b1;
      cnt_r    <= cnt_r + CNT_W'(pop8);
    end
    if (op.out_ld && out_free) begin
      out_slot_r  <= j_r;
      out_mask_r  <= mask_r;
      out_count_r <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op.out_ld && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_queried_slot = out_slot_r;
  assign out_start_mask   = out_mask_r;
  assign out_start_count  = out_count_r;

  a_shift_has_copy: assert property (@(posedge clk) disable iff (!rst_n)
    op.shift |-> (k_r != '0))
    else $error("shift step entered with no copies left");

  a_origin_kept: assert property (@(posedge clk) disable iff (!rst_n)
    op.shift |-> mask_r[0])
    else $error("position zero lost during the reach walk");

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (op.out_ld && out_free) |=> (out_count_r == CNT_W'($countones(out_mask_r))))
    else $error("start count disagrees with start mask");

endmodule

// ===== test/normal_pattern_reachability_test.sv =====
// Self-checking testbench for normal_pattern_reachability: a directed table, then random requests.
// Depends on nprc_pkg and the block itself; each result is checked against an in-bench predictor or a typed row.
`timescale 1ns / 100ps

module normal_pattern_reachability_test;
  import nprc_pkg::*;

  localparam int PERIOD       = 8;
  localparam int MASK_W       = DEF_MAX_WIDTH;
  localparam int CNT_W        = $clog2(DEF_MAX_WIDTH + 1);
  // A query walks at most 16 types. It also runs under 80 shift-OR steps, because each
  // productive step adds a start and each type ends on one idle step. With the byte count
  // after the walk, SETTLE_CYCLES covers any request still in flight.
  localparam int SETTLE_CYCLES = 160;
  localparam int HOLD_CYCLES   = 600;
  localparam int PHASE_ITEMS   = 200;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [MASK_W-1:0] mask;
    logic [CNT_W-1:0]  count;
  } starts_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // One row of the directed table. It is either a register write or a request. A request
  // row with typed set carries its own expected result and does not use the predictor.
  typedef struct packed {
    row_kind_t             row;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DAT_W-1:0]  reg_val;
    logic                  kind;
    logic [SLOT_W-1:0]     slot;
    logic [IW_W-1:0]       width;
    logic [DEM_W-1:0]      demand;
    bit                    typed;
    logic [MASK_W-1:0]     mask;
    logic [CNT_W-1:0]      count;
  } dir_row_t;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 cfg_valid      = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [CFG_DAT_W-1:0] cfg_data       = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic                 in_kind        = KIND_LOAD;
  logic [SLOT_W-1:0]    in_slot        = '0;
  logic [IW_W-1:0]      in_item_width  = '0;
  logic [DEM_W-1:0]     in_item_demand = '0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic [SLOT_W-1:0]    out_queried_slot;
  logic [MASK_W-1:0]    out_start_mask;
  logic [CNT_W-1:0]     out_start_count;

  // This is the predictor's own copy of the type table and of the two registers.
  logic [IW_W-1:0]  width_tbl  [DEF_MAX_TYPES];
  logic [DEM_W-1:0] demand_tbl [DEF_MAX_TYPES];
  logic [SW_W-1:0]  strip_reg = 7'd64;
  logic [TT_W-1:0]  total_reg = '0;

  starts_t     pending_starts[$];
  dir_row_t    dir_rows[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;
  bit          hold_pending   = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  normal_pattern_reachability u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_slot          (in_slot),
    .in_item_width    (in_item_width),
    .in_item_demand   (in_item_demand),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_queried_slot (out_queried_slot),
    .out_start_mask   (out_start_mask),
    .out_start_count  (out_start_count)
  );

  always #(PERIOD / 2) clk = ~clk;

  // This returns a mask with the n lowest bits set. A count of 64 or more gives all ones.
  function automatic logic [MASK_W-1:0] low_ones(input int unsigned n);
    if (n >= MASK_W) begin
      return '1;
    end
    return (64'd1 << n) - 64'd1;
  endfunction

  // This computes the normal-pattern starts of one slot. Reach begins at position 0. Every
  // counted copy of each taking-part type shifts the reach by that type's width and ORs it
  // in, and the queried type counts one copy fewer. A type stops adding copies once a copy
  // brings no new start. The result is then clipped to the starts where the queried item
  // still fits in the strip.
  function automatic logic [MASK_W-1:0] reach_starts(input logic [SLOT_W-1:0] slot);
    int unsigned w, n, own_w, tw, lim, t, k;
    logic [MASK_W-1:0] wmask, mask, grown;
    w = (strip_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : strip_reg;
    n = (total_reg > DEF_MAX_TYPES) ? DEF_MAX_TYPES : total_reg;
    if (w == 0 || slot >= n) begin
      return '0;
    end
    if (demand_tbl[slot] == 0) begin
      return '0;
    end
    own_w = width_tbl[slot];
    if (own_w > w) begin
      return '0;
    end
    wmask = low_ones(w);
    mask  = 64'd1;
    for (t = 0; t < n; t++) begin
      tw  = width_tbl[t];
      lim = demand_tbl[t];
      if (t == slot) begin
        lim--;
      end
      if (tw != 0 && tw < w) begin
        for (k = 0; k < lim; k++) begin
          grown = mask | ((mask << tw) & wmask);
          if (grown == mask) begin
            break;
          end
          mask = grown;
        end
      end
    end
    return mask & wmask & low_ones(w - own_w + 1);
  endfunction

  function automatic dir_row_t req_row(input logic kind, input logic [SLOT_W-1:0] slot,
                                       input logic [IW_W-1:0] width,
                                       input logic [DEM_W-1:0] demand);
    dir_row_t r;
    r        = '0;
    r.row    = ROW_REQ;
    r.kind   = kind;
    r.slot   = slot;
    r.width  = width;
    r.demand = demand;
    return r;
  endfunction

  // This builds a query row whose result can be written down by hand.
  function automatic dir_row_t typed_row(input logic [SLOT_W-1:0] slot,
                                         input logic [MASK_W-1:0] mask,
                                         input logic [CNT_W-1:0] count);
    dir_row_t r;
    r       = '0;
    r.row   = ROW_REQ;
    r.kind  = KIND_QUERY;
    r.slot  = slot;
    r.typed = 1'b1;
    r.mask  = mask;
    r.count = count;
    return r;
  endfunction

  function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DAT_W-1:0] val);
    dir_row_t r;
    r         = '0;
    r.row     = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // This appends one row to the end of the directed table.
  function automatic void add_row(input dir_row_t r);
    dir_rows = {dir_rows, r};
  endfunction

  // Most widths are small, so that reaches take many steps. Some are zero and some are at
  // or above the strip, and those cover the upper bits.
  function automatic logic [IW_W-1:0] rand_width();
    case ($urandom_range(9))
      0: return '0;
      1: return IW_W'($urandom_range(64, 127));
      default: return IW_W'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic logic [DEM_W-1:0] rand_demand();
    case ($urandom_range(9))
      0: return '0;
      1: return DEM_W'($urandom_range(0, 255));
      default: return DEM_W'($urandom_range(1, 6));
    endcase
  endfunction

  // This offers one request on the input channel. Idle cycles go before it, and valid
  // stays up with a steady payload until the block takes the request. At the edge of
  // acceptance a load updates the predictor's table, and a query queues its expected result.
  task automatic issue_request(input logic kind, input logic [SLOT_W-1:0] slot,
                               input logic [IW_W-1:0] width, input logic [DEM_W-1:0] demand,
                               input bit typed, input logic [MASK_W-1:0] typed_mask,
                               input logic [CNT_W-1:0] typed_count);
    starts_t due;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_slot        <= slot;
    in_item_width  <= width;
    in_item_demand <= demand;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind == KIND_LOAD) begin
      width_tbl[slot]  = width;
      demand_tbl[slot] = demand;
    end else begin
      due.slot  = slot;
      due.mask  = typed ? typed_mask : reach_starts(slot);
      due.count = typed ? typed_count : CNT_W'($countones(due.mask));
      pending_starts = {pending_starts, due};
    end
  endtask

  // This writes one register and mirrors it into the predictor. Only the low five bits
  // of the data reach type_total.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_STRIP_WIDTH) begin
      strip_reg = val;
    end else begin
      total_reg = val[TT_W-1:0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // This withdraws the last request, then waits until every queued query has returned.
  // A load gives no result and leaves the block idle; the task still also waits out the
  // longest request.
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_starts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The receiver side. A requested hold-off keeps out_ready low for a long stretch, which
  // lets one result wait, a second query finish behind it and the input stall. Outside a
  // hold-off, ready drops at the phase's stall rate.
  always @(negedge clk) begin
    if (hold_pending) begin
      hold_pending = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Each accepted result is compared field by field with the oldest expectation.
  always @(posedge clk) begin : check_result
    starts_t due;
    if (rst_n && out_valid && out_ready) begin
      if (pending_starts.size() == 0) begin
        $display("%0t: result for slot %0d with no query waiting", $time, out_queried_slot);
        mismatch_count++;
      end else begin
        due = pending_starts.pop_front();
        if (out_queried_slot !== due.slot) begin
          $display("%0t: queried_slot expected %0d, got %0d", $time, due.slot,
                   out_queried_slot);
          mismatch_count++;
        end
        if (out_start_mask !== due.mask) begin
          $display("%0t: start_mask of slot %0d expected %h, got %h", $time, due.slot,
                   due.mask, out_start_mask);
          mismatch_count++;
        end
        if (out_start_count !== due.count) begin
          $display("%0t: start_count of slot %0d expected %0d, got %0d", $time, due.slot,
                   due.count, out_start_count);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("normal_pattern_reachability_test: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned p, i, s, n_eff, mode;
    logic [CFG_DAT_W-1:0] sw_val, tt_val;

    // The directed part starts from the reset values, with W at 64 and no types taking part.
    // No query reads a slot before that slot has been loaded.
    add_row(req_row(KIND_LOAD, 4'd0, 7'd10, 8'd3));
    add_row(typed_row(4'd0, '0, '0));           // no type takes part yet
    add_row(reg_row(CFG_TYPE_TOTAL, 7'd1));
    add_row(req_row(KIND_QUERY, 4'd0, 7'd0, 8'd0));
    add_row(req_row(KIND_LOAD, 4'd1, 7'd0, 8'd255));   // zero width, full demand
    add_row(req_row(KIND_LOAD, 4'd2, 7'd127, 8'd1));   // wider than any strip
    add_row(req_row(KIND_LOAD, 4'd3, 7'd64, 8'd0));    // no copies at all
    add_row(reg_row(CFG_TYPE_TOTAL, 7'd4));
    add_row(req_row(KIND_QUERY, 4'd1, 7'd127, 8'd255)); // zero width: fits at every reach
    add_row(typed_row(4'd2, '0, '0));           // own width above the strip
    add_row(typed_row(4'd3, '0, '0));           // own demand zero
    add_row(req_row(KIND_LOAD, 4'd15, 7'd85, 8'd170));
    add_row(typed_row(4'd15, '0, '0));          // slot beyond type_total
    add_row(reg_row(CFG_STRIP_WIDTH, 7'd0));
    add_row(typed_row(4'd0, '0, '0));           // empty strip
    add_row(reg_row(CFG_STRIP_WIDTH, 7'd1));
    add_row(typed_row(4'd1, 64'd1, 7'd1));      // one position only
    add_row(reg_row(CFG_STRIP_WIDTH, 7'd127));  // saturates to 64
    add_row(req_row(KIND_QUERY, 4'd0, 7'd0, 8'd0));
    add_row(req_row(KIND_LOAD, 4'd4, 7'd1, 8'd255));
    add_row(reg_row(CFG_TYPE_TOTAL, 7'd5));
    add_row(typed_row(4'd1, '1, 7'd64));        // unit widths fill the strip
    add_row(req_row(KIND_LOAD, 4'd3, 7'd64, 8'd2));
    add_row(typed_row(4'd3, 64'd1, 7'd1));      // fits only at position 0
    add_row(req_row(KIND_QUERY, 4'd4, 7'd0, 8'd0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].row == ROW_CFG) begin
        settle_block();
        write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
      end else begin
        issue_request(dir_rows[r].kind, dir_rows[r].slot, dir_rows[r].width,
                      dir_rows[r].demand, dir_rows[r].typed, dir_rows[r].mask,
                      dir_rows[r].count);
      end
    end

    // The random part runs in phases. Each phase writes both registers while the block is
    // idle and picks an idling pattern. The first phase loads every slot, so later queries
    // may name any slot and any type_total.
    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin sw_val = 7'd64;  tt_val = 7'd16; mode = 0; end
        1: begin sw_val = 7'd40;  tt_val = 7'd31; mode = 1; end  // type_total saturates
        2: begin sw_val = 7'd127; tt_val = 7'd8;  mode = 2; end
        3: begin sw_val = 7'd2;   tt_val = 7'd16; mode = 3; end
        4: begin sw_val = 7'd23;  tt_val = 7'd5;  mode = 0; end
        default: begin
          sw_val = CFG_DAT_W'($urandom_range(1, 127));
          tt_val = CFG_DAT_W'($urandom_range(0, 31));
          mode   = $urandom_range(3);
        end
      endcase
      settle_block();
      write_reg(CFG_STRIP_WIDTH, sw_val);
      write_reg(CFG_TYPE_TOTAL, tt_val);
      case (mode)
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        3: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (p == 0) begin
        for (s = 0; s < DEF_MAX_TYPES; s++) begin
          issue_request(KIND_LOAD, SLOT_W'(s), rand_width(), rand_demand(), 1'b0, '0, '0);
        end
      end
      // In this phase the receiver holds off while queries keep coming.
      if (p == 4) begin
        hold_pending = 1'b1;
      end
      for (i = 0; i < PHASE_ITEMS; i++) begin
        n_eff = (total_reg > DEF_MAX_TYPES) ? DEF_MAX_TYPES : total_reg;
        if ($urandom_range(99) < 30) begin
          issue_request(KIND_LOAD, SLOT_W'($urandom_range(15)), rand_width(), rand_demand(),
                        1'b0, '0, '0);
        end else if (n_eff != 0 && $urandom_range(99) < 85) begin
          issue_request(KIND_QUERY, SLOT_W'($urandom_range(n_eff - 1)), IW_W'($urandom),
                        DEM_W'($urandom), 1'b0, '0, '0);
        end else begin
          issue_request(KIND_QUERY, SLOT_W'($urandom_range(15)), IW_W'($urandom),
                        DEM_W'($urandom), 1'b0, '0, '0);
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    settle_block();

    if (mismatch_count == 0) begin
      $display("normal_pattern_reachability_test: done, clean");
    end else begin
      $display("normal_pattern_reachability_test: done, errors");
    end
    $finish;
  end

endmodule
